>>> rtl/evm_byte_memory_unit_defines.svh
// Assertion macros for the byte memory unit checker.
// Needs clk and rst in scope at the point of use; no other dependencies.
`ifndef EVM_BYTE_MEMORY_UNIT_DEFINES_SVH
`define EVM_BYTE_MEMORY_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define EBMU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ebmu check failed");

// Implication with a fixed delay, disabled while in reset.
`define EBMU_ASSERT_DELAY(label, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error("ebmu check failed");

`endif

>>> rtl/ebmu_pkg.sv
// Shared types and constants for the byte memory unit.
// No dependencies; used by the lane, merge and top-level modules.
package ebmu_pkg;

  localparam int WORD_BYTES = 32;
  localparam int LANE_W     = 5;
  localparam int OFFSET_W   = 16;
  localparam int SIZE_W     = 17;
  localparam int DATA_W     = 64;
  // offset[15:5] plus a carry into the next row
  localparam int ROW_FULL_W = OFFSET_W - LANE_W + 1;
  // packed byte index of the store-byte value (low byte of field 0)
  localparam int BYTE_VAL_IDX = WORD_BYTES - 8;

  typedef enum logic [1:0] {
    ACT_LOAD       = 2'd0,
    ACT_STORE_WORD = 2'd1,
    ACT_STORE_BYTE = 2'd2,
    ACT_TOUCH      = 2'd3
  } action_t;

  // word byte i (big-endian order) sits at packed index WORD_BYTES-1-i
  typedef logic [WORD_BYTES-1:0][7:0] word_bytes_t;

  // bank-indexed bytes: element b comes from bank b
  typedef logic [WORD_BYTES-1:0][7:0] bank_bytes_t;

  typedef struct packed {
    logic                  clear;
    logic                  wr_word;
    logic                  wr_byte;
    logic [OFFSET_W-1:0]   offset;
    logic [ROW_FULL_W-1:0] clr_row;
  } lane_cmd_t;

  typedef struct packed {
    logic              valid;
    logic              load_ok;
    logic              oor;
    logic [LANE_W-1:0] rot;
    logic [SIZE_W-1:0] size;
  } res_info_t;

endpackage

>>> rtl/ebmu_lane.sv
// One byte bank of the memory: row address, write select and a registered read.
// Depends on ebmu_pkg.
module ebmu_lane #(
  parameter int LANE = 0,
  parameter int ROWS = 2048,
  parameter int RW   = 11
) (
  input  logic                    clk,
  input  ebmu_pkg::lane_cmd_t     cmd,
  input  ebmu_pkg::word_bytes_t   store_word,
  output logic [7:0]              rd_byte
);

  localparam logic [ebmu_pkg::LANE_W-1:0] BANK = ebmu_pkg::LANE_W'(LANE);

  logic [ebmu_pkg::LANE_W-1:0]     word_idx;
  logic [ebmu_pkg::ROW_FULL_W-1:0] row_full;
  logic [RW-1:0]                   row;
  logic                            we;
  logic [7:0]                      wdata;
  logic [7:0]                      mem [ROWS];

  // bank position within the word; banks below the start column fall in the next row
  assign word_idx = BANK - cmd.offset[ebmu_pkg::LANE_W-1:0];
  assign row_full = {1'b0, cmd.offset[ebmu_pkg::OFFSET_W-1:ebmu_pkg::LANE_W]}
                  + ((BANK < cmd.offset[ebmu_pkg::LANE_W-1:0]) ?
                     ebmu_pkg::ROW_FULL_W'(1) : ebmu_pkg::ROW_FULL_W'(0));

  always_comb begin
    if (cmd.clear) begin
      row   = cmd.clr_row[RW-1:0];
      we    = 1'b1;
      wdata = 8'h00;
    end else begin
      row   = row_full[RW-1:0];
      we    = cmd.wr_word || (cmd.wr_byte && (word_idx == '0));
      wdata = cmd.wr_byte ? store_word[ebmu_pkg::BYTE_VAL_IDX]
                          : store_word[~word_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[row] <= wdata;
    end
    rd_byte <= mem[row];
  end

endmodule

>>> rtl/ebmu_merge.sv
// Rotates the bank read bytes back into word order and registers the result.
// Depends on ebmu_pkg.
module ebmu_merge (
  input  logic                                clk,
  input  logic                                rst,
  input  ebmu_pkg::res_info_t                 info,
  input  ebmu_pkg::bank_bytes_t               lane_bytes,
  output logic                                done,
  output logic [ebmu_pkg::DATA_W-1:0]         read_word_0,
  output logic [ebmu_pkg::DATA_W-1:0]         read_word_1,
  output logic [ebmu_pkg::DATA_W-1:0]         read_word_2,
  output logic [ebmu_pkg::DATA_W-1:0]         read_word_3,
  output logic [ebmu_pkg::SIZE_W-1:0]         active_size,
  output logic                                out_of_range
);

  ebmu_pkg::word_bytes_t rd_bytes;

  // word byte i lives in bank (offset + i) mod 32
  always_comb begin
    for (int i = 0; i < ebmu_pkg::WORD_BYTES; i++) begin
      rd_bytes[ebmu_pkg::WORD_BYTES-1-i] =
        info.load_ok ? lane_bytes[info.rot + ebmu_pkg::LANE_W'(i)] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= info.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (info.valid) begin
      {read_word_0, read_word_1, read_word_2, read_word_3} <= rd_bytes;
      active_size  <= info.size;
      out_of_range <= info.oor;
    end
  end

endmodule

>>> rtl/evm_byte_memory_unit.sv
// Top level of the byte-addressed stack-machine memory: 32 byte-bank lanes and a merge stage.
// Depends on ebmu_pkg, ebmu_lane and ebmu_merge.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------------
//  request  | start / busy       | action, offset, span, data_word_0..3
//  result   | done (one cycle)   | read_word_0..3, active_size, out_of_range
//
// Timing: one request transfer per clock while busy is low. Three register stages (capture,
//   bank access, merge): done is registered in the merge stage after capture and bank access.
//   Throughput is set by the 32 single-port byte banks: one row access per bank per cycle
//   covers any unaligned 32-byte word.
// Reset: rst clears control, then a clearing pass zeroes one row of all banks per cycle,
//   ROWS rows in all (2048 at the default MEM_BYTES); busy is high through rst and the pass.
// Stalls: the receiver cannot stall; busy only rises for reset and the clearing pass.
module evm_byte_memory_unit #(
  parameter int MEM_BYTES = 65536
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          action,
  input  logic [ebmu_pkg::OFFSET_W-1:0]       offset,
  input  logic [ebmu_pkg::SIZE_W-1:0]         span,
  input  logic [ebmu_pkg::DATA_W-1:0]         data_word_0,
  input  logic [ebmu_pkg::DATA_W-1:0]         data_word_1,
  input  logic [ebmu_pkg::DATA_W-1:0]         data_word_2,
  input  logic [ebmu_pkg::DATA_W-1:0]         data_word_3,
  output logic                                done,
  output logic [ebmu_pkg::DATA_W-1:0]         read_word_0,
  output logic [ebmu_pkg::DATA_W-1:0]         read_word_1,
  output logic [ebmu_pkg::DATA_W-1:0]         read_word_2,
  output logic [ebmu_pkg::DATA_W-1:0]         read_word_3,
  output logic [ebmu_pkg::SIZE_W-1:0]         active_size,
  output logic                                out_of_range
);

  // Highest byte address any load or store can reach is 65535 + 31.
  localparam int MAX_BYTES   = (1 << ebmu_pkg::OFFSET_W) + ebmu_pkg::WORD_BYTES - 1;
  localparam int STORE_BYTES = (MEM_BYTES < MAX_BYTES) ? MEM_BYTES : MAX_BYTES;
  localparam int ROWS        = (STORE_BYTES + ebmu_pkg::WORD_BYTES - 1) / ebmu_pkg::WORD_BYTES;
  localparam int RW          = $clog2(ROWS);

  // clearing pass
  logic          clearing;
  logic [RW-1:0] clr_row;

  // stage 1: captured request
  logic                             valid1;
  ebmu_pkg::action_t                act1;
  logic [ebmu_pkg::OFFSET_W-1:0]    off1;
  logic [ebmu_pkg::SIZE_W-1:0]      span1;
  ebmu_pkg::word_bytes_t            data1;

  // size tracking
  logic [ebmu_pkg::SIZE_W-1:0]      high_water;
  logic [ebmu_pkg::SIZE_W-1:0]      high_water_next;

  logic                             accept;
  logic [ebmu_pkg::SIZE_W-1:0]      len;
  logic [ebmu_pkg::SIZE_W-1:0]      end_addr;
  logic                             empty;
  logic                             oor;
  logic                             ok;

  ebmu_pkg::lane_cmd_t              lane_cmd;
  ebmu_pkg::res_info_t              info2;
  ebmu_pkg::bank_bytes_t            lane_bytes;

  assign busy   = rst || clearing;
  assign accept = start && !busy;

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clr_row    <= '0;
      valid1     <= 1'b0;
      high_water <= '0;
    end else begin
      if (clearing && (clr_row == RW'(ROWS - 1))) begin
        clearing <= 1'b0;
      end
      if (clearing) begin
        clr_row <= clr_row + RW'(1);
      end
      valid1     <= accept;
      high_water <= high_water_next;
    end
  end

  // ---- request capture ----
  always_ff @(posedge clk) begin
    if (accept) begin
      act1  <= ebmu_pkg::action_t'(action);
      off1  <= offset;
      span1 <= span;
      data1 <= {data_word_0, data_word_1, data_word_2, data_word_3};
    end
  end

  // ---- access length and range check ----
  always_comb begin
    case (act1)
      ebmu_pkg::ACT_STORE_BYTE: len = ebmu_pkg::SIZE_W'(1);
      ebmu_pkg::ACT_TOUCH:      len = span1;
      default:                  len = ebmu_pkg::SIZE_W'(ebmu_pkg::WORD_BYTES);
    endcase
  end

  // max end is 65535 + 131071, which overflows 17 bits and wraps
  assign end_addr = {1'b0, off1} + len;
  assign empty    = (len == '0);
  assign oor      = !empty && (32'(end_addr) > 32'(MEM_BYTES));
  assign ok       = valid1 && !oor;

  // every in-range access with a nonzero length raises the size to its end address if that is larger
  always_comb begin
    high_water_next = high_water;
    if (ok && !empty && (end_addr > high_water)) begin
      high_water_next = end_addr;
    end
  end

  // ---- lane command: clearing pass has priority; no request is in flight then ----
  always_comb begin
    lane_cmd.clear   = clearing;
    lane_cmd.wr_word = ok && (act1 == ebmu_pkg::ACT_STORE_WORD);
    lane_cmd.wr_byte = ok && (act1 == ebmu_pkg::ACT_STORE_BYTE);
    lane_cmd.offset  = off1;
    lane_cmd.clr_row = ebmu_pkg::ROW_FULL_W'(clr_row);
  end

  // ---- stage 2: result info travels alongside the bank reads ----
  always_ff @(posedge clk) begin
    if (rst) begin
      info2.valid <= 1'b0;
    end else begin
      info2.valid <= valid1;
    end
    info2.load_ok <= ok && (act1 == ebmu_pkg::ACT_LOAD);
    info2.oor     <= oor;
    info2.rot     <= off1[ebmu_pkg::LANE_W-1:0];
    info2.size    <= high_water_next;
  end

  // ---- byte-bank lanes ----
  for (genvar b = 0; b < ebmu_pkg::WORD_BYTES; b++) begin : g_lane
    ebmu_lane #(
      .LANE (b),
      .ROWS (ROWS),
      .RW   (RW)
    ) u_lane (
      .clk        (clk),
      .cmd        (lane_cmd),
      .store_word (data1),
      .rd_byte    (lane_bytes[b])
    );
  end

  // ---- merge and result registers ----
  ebmu_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .info         (info2),
    .lane_bytes   (lane_bytes),
    .done         (done),
    .read_word_0  (read_word_0),
    .read_word_1  (read_word_1),
    .read_word_2  (read_word_2),
    .read_word_3  (read_word_3),
    .active_size  (active_size),
    .out_of_range (out_of_range)
  );

endmodule

>>> rtl/ebmu_checker.sv
// Port-level checks for the byte memory unit, bound to the top level.
// Depends on evm_byte_memory_unit_defines.svh and ebmu_pkg.
`include "evm_byte_memory_unit_defines.svh"

module ebmu_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [ebmu_pkg::DATA_W-1:0]   read_word_0,
  input logic [ebmu_pkg::DATA_W-1:0]   read_word_1,
  input logic [ebmu_pkg::DATA_W-1:0]   read_word_2,
  input logic [ebmu_pkg::DATA_W-1:0]   read_word_3,
  input logic [ebmu_pkg::SIZE_W-1:0]   active_size,
  input logic                          out_of_range
);

  logic rd_zero;

  assign rd_zero = (read_word_0 == '0) && (read_word_1 == '0) &&
                   (read_word_2 == '0) && (read_word_3 == '0);

  // each transfer yields a result, and each result comes from a transfer
  `EBMU_ASSERT_DELAY(a_latency, start && !busy, 3, done)
  `EBMU_ASSERT_NOW(a_done_src, done, $past(start && !busy, 3))
  // rejected accesses return no data
  `EBMU_ASSERT_NOW(a_oor_zero, done && out_of_range, rd_zero)
  // the active size never shrinks between back-to-back results
  `EBMU_ASSERT_NOW(a_size_grows, done && $past(done), active_size >= $past(active_size))
  // nothing completes during the clearing pass
  `EBMU_ASSERT_NOW(a_quiet_busy, busy, !done)

endmodule

bind evm_byte_memory_unit ebmu_checker u_ebmu_checker (.*);
